FILE: design/idll_pkg.sv
// Package with the shared types and constants of the indexed doubly linked list.
package idll_pkg;

  localparam int NODE_W = 10;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [1:0] {
    OP_UNLINK     = 2'd0,
    OP_INS_BEFORE = 2'd1,
    OP_INS_AFTER  = 2'd2,
    OP_QUERY      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WB
  } state_e;

  // One link table write: enable, node index and link value.
  typedef struct packed {
    logic  en;
    node_t addr;
    node_t data;
  } link_wr_t;

endpackage

FILE: design/idll_link_ram.sv
// One link table: simple dual-port memory with registered, write-first read.
module idll_link_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output idll_pkg::node_t      rd_data_o,
  input  logic                 we_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  idll_pkg::node_t      wr_data_i
);
  import idll_pkg::*;

  node_t mem [DEPTH];
  node_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // A read that hits the entry being written returns the new value.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (we_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/indexed_doubly_linked_list_top.sv
// Top level of the indexed doubly linked list with previous and next link tables.
// Query: both tables are read on the input transfer; the result is registered in
// the execute state once the output is free. Items are taken only in the idle or
// write-back state, where a read and the deferred write share a cycle by bypass.
// Reset: after rst_ni rises, a clearing pass writes zero to NODE_COUNT+1 entries,
// one per cycle, while in_stall_o stays high.
module indexed_doubly_linked_list_top #(
  parameter int NODE_COUNT = 1023
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  idll_pkg::op_e    opcode_i,
  input  idll_pkg::node_t  node_a_i,
  input  idll_pkg::node_t  node_b_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output idll_pkg::node_t  prev_node_o,
  output idll_pkg::node_t  next_node_o
);
  import idll_pkg::*;

  localparam int DEPTH = NODE_COUNT + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [16:0] NODE_LIMIT = 17'(NODE_COUNT);

  state_e   state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;

  op_e      op_q;
  node_t    a_q, b_q;
  logic     a_ok_q, b_ok_q;
  link_wr_t wb_prev_q, wb_next_q;

  logic     out_valid_q, out_valid_d;
  node_t    prev_out_q, next_out_q;

  logic     accept, do_wr, out_load;
  node_t    pa, na;
  link_wr_t p_w1, p_w2, n_w1, n_w2;

  logic          prev_we, next_we;
  logic [AW-1:0] prev_wa, next_wa;
  node_t         prev_wd, next_wd;

  assign in_stall_o = !((state_q == ST_IDLE) || (state_q == ST_WB));
  assign accept     = in_valid_i && !in_stall_o;

  idll_link_ram #(.DEPTH(DEPTH), .AW(AW)) u_prev_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (AW'(node_a_i)),
    .rd_data_o (pa),
    .we_i      (prev_we),
    .wr_addr_i (prev_wa),
    .wr_data_i (prev_wd)
  );

  idll_link_ram #(.DEPTH(DEPTH), .AW(AW)) u_next_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (AW'(node_a_i)),
    .rd_data_o (na),
    .we_i      (next_we),
    .wr_addr_i (next_wa),
    .wr_data_i (next_wd)
  );

  assign do_wr = a_ok_q && (op_q != OP_QUERY) && ((op_q == OP_UNLINK) || b_ok_q);

  // The second write of each table wins on a shared entry, so it goes first and
  // the earlier write is deferred to the next cycle only when the entries differ.
  always_comb begin
    p_w1 = '0;
    p_w2 = '0;
    n_w1 = '0;
    n_w2 = '0;
    case (op_q)
      OP_UNLINK: begin
        p_w2 = '{en: 1'b1, addr: a_q, data: '0};
        p_w1 = '{en: (na != '0), addr: na, data: pa};
        n_w2 = '{en: 1'b1, addr: a_q, data: '0};
        n_w1 = '{en: (pa != '0), addr: pa, data: na};
      end
      OP_INS_BEFORE: begin
        p_w2 = '{en: 1'b1, addr: a_q, data: b_q};
        p_w1 = '{en: (pa != '0), addr: b_q, data: pa};
        n_w2 = '{en: 1'b1, addr: b_q, data: a_q};
        n_w1 = '{en: (pa != '0), addr: pa, data: b_q};
      end
      OP_INS_AFTER: begin
        p_w2 = '{en: 1'b1, addr: b_q, data: a_q};
        p_w1 = '{en: (na != '0), addr: na, data: b_q};
        n_w2 = '{en: 1'b1, addr: a_q, data: b_q};
        n_w1 = '{en: (na != '0), addr: b_q, data: na};
      end
      default: begin
      end
    endcase
    p_w2.en = p_w2.en && do_wr;
    n_w2.en = n_w2.en && do_wr;
    p_w1.en = p_w1.en && do_wr && (p_w1.addr != p_w2.addr);
    n_w1.en = n_w1.en && do_wr && (n_w1.addr != n_w2.addr);
  end

  always_comb begin
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    case (state_q)
      ST_CLEAR: begin
        prev_we = 1'b1;
        prev_wa = clr_q;
        next_we = 1'b1;
        next_wa = clr_q;
      end
      ST_EXEC: begin
        prev_we = p_w2.en;
        prev_wa = AW'(p_w2.addr);
        prev_wd = p_w2.data;
        next_we = n_w2.en;
        next_wa = AW'(n_w2.addr);
        next_wd = n_w2.data;
      end
      ST_WB: begin
        prev_we = wb_prev_q.en;
        prev_wa = AW'(wb_prev_q.addr);
        prev_wd = wb_prev_q.data;
        next_we = wb_next_q.en;
        next_wa = AW'(wb_next_q.addr);
        next_wd = wb_next_q.data;
      end
      default: begin
      end
    endcase
  end

  assign out_load = (state_q == ST_EXEC) && (op_q == OP_QUERY) &&
                    (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = (out_valid_q && out_stall_i) || out_load;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(NODE_COUNT)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_q == OP_QUERY) begin
          if (out_load) begin
            state_d = ST_IDLE;
          end
        end else if (do_wr) begin
          state_d = ST_WB;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WB: begin
        state_d = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      a_ok_q <= (node_a_i != '0) && (17'(node_a_i) <= NODE_LIMIT);
      b_ok_q <= (node_b_i != '0) && (17'(node_b_i) <= NODE_LIMIT);
    end
    if (state_q == ST_EXEC) begin
      wb_prev_q <= p_w1;
      wb_next_q <= n_w1;
    end
    if (out_load) begin
      prev_out_q <= a_ok_q ? pa : '0;
      next_out_q <= a_ok_q ? na : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign prev_node_o = prev_out_q;
  assign next_node_o = next_out_q;

endmodule

FILE: design/idll_checker.sv
// Port-level checker for the indexed doubly linked list, bound to the top level.
module idll_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input idll_pkg::op_e    opcode_i,
  input idll_pkg::node_t  node_a_i,
  input idll_pkg::node_t  node_b_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input idll_pkg::node_t  prev_node_o,
  input idll_pkg::node_t  next_node_o
);
  import idll_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(prev_node_o) && $stable(next_node_o))
    else $error("result changed while stalled");

  // Every transfer occupies the block for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken in the cycle after a transfer");

  // A result appears only in answer to an earlier query transfer.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && (opcode_i == OP_QUERY), 2))
    else $error("result without a matching query");

  // Non-query operations never produce a result on their own.
  a_no_result_for_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i != OP_QUERY) && !out_valid_o |=>
      ##1 !$rose(out_valid_o))
    else $error("result produced by an update");

endmodule

bind indexed_doubly_linked_list_top idll_checker u_idll_checker (.*);
